FILE: hw/rtl/rlpg_pkg.sv
package rlpg_pkg;

  localparam int TIME_W      = 32;
  localparam int LEVEL_W     = 8;
  localparam int DUTY_W      = 16;
  localparam int SPAN_W      = 16;
  localparam int COUNT_W     = 8;
  localparam int DIVISOR_W   = SPAN_W + 1;
  localparam int DIV_CNT_W   = $clog2(TIME_W);
  localparam int PROD_W      = SPAN_W + 9;
  localparam int LIT_W       = COUNT_W + SPAN_W + 1;
  localparam int TOTAL_W     = LIT_W + 1;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 16;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 56;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'd255;

  typedef enum logic [1:0] {
    MODE_OFF    = 2'd0,
    MODE_ON     = 2'd1,
    MODE_BREATH = 2'd2,
    MODE_BLINK  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE   = 8'd0,
    REG_RED    = 8'd1,
    REG_GREEN  = 8'd2,
    REG_BLUE   = 8'd3,
    REG_PERIOD = 8'd4,
    REG_COUNT  = 8'd5,
    REG_HALF   = 8'd6,
    REG_GAP    = 8'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BREATH_MOD,
    ST_BREATH_SCALE,
    ST_BREATH_DIV,
    ST_BLINK_SPAN,
    ST_BLINK_TEST,
    ST_BLINK_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [TIME_W-1:0]    dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [TIME_W-1:0]    quotient;
    logic [DIVISOR_W-1:0] remainder;
  } div_rsp_t;

endpackage

FILE: hw/rtl/rlpg_div.sv
module rlpg_div
  import rlpg_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [TIME_W-1:0]    quo;
  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dvs;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 fits;

  // One restoring step per cycle: the dividend shifts out of quo as the
  // quotient bits shift in behind it.
  assign trial = {rem, quo[TIME_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = trial >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(TIME_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
      dvs <= req.divisor;
    end else if (busy) begin
      rem <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo <= {quo[TIME_W-2:0], fits};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

FILE: hw/rtl/rgb_led_pattern_generator.sv
// Channel   Direction  Handshake                   Payload
// s_axis    in         s_axis_tvalid/s_axis_tready now_ms
// m_axis    out        m_axis_tvalid/m_axis_tready red, green, blue duty, brightness
// cfg       in         cfg_valid/cfg_ready         cfg_index, cfg_data
//
// Off and on items go from idle to the done state, which loads the output
// register once free. Breathing with a nonzero period makes two passes of the
// shared bit-serial divider (32 steps each), for the period remainder and the
// scaling. Blinking uses the divider only when the pulse remainder is needed.
// Synchronous active-high reset clears the registers, the burst start time
// and the brightness. The next item is taken once the result is registered;
// a stalled result holds in the output register.
module rgb_led_pattern_generator
  import rlpg_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [31:0] now_ms
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [15:0] red_duty, [31:16] green_duty, [47:32] blue_duty, [55:48] brightness
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  mode_t               mode;
  logic [LEVEL_W-1:0]  red_level;
  logic [LEVEL_W-1:0]  green_level;
  logic [LEVEL_W-1:0]  blue_level;
  logic [SPAN_W-1:0]   breath_period;
  logic [COUNT_W-1:0]  pulse_count;
  logic [SPAN_W-1:0]   pulse_half;
  logic [SPAN_W-1:0]   gap;

  state_t              state;
  state_t              state_next;
  logic [TIME_W-1:0]   now_r;
  logic [TIME_W-1:0]   burst_start;
  logic [LEVEL_W-1:0]  bright;
  logic [PROD_W-1:0]   prod;
  logic [LIT_W-1:0]    lit;
  logic [TIME_W-1:0]   elapsed;
  logic [DUTY_W-1:0]   red_duty;
  logic [DUTY_W-1:0]   green_duty;
  logic [DUTY_W-1:0]   blue_duty;
  logic [LEVEL_W-1:0]  bright_out;
  logic                out_valid;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic                in_take;
  logic                out_free;
  logic                out_load;
  logic [SPAN_W-1:0]   t_mod;
  logic [SPAN_W-1:0]   x_fold;
  logic [TOTAL_W-1:0]  total;
  logic                burst_over;
  logic                in_gap;

  rlpg_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_OFF;
      red_level     <= '0;
      green_level   <= '0;
      blue_level    <= '0;
      breath_period <= '0;
      pulse_count   <= '0;
      pulse_half    <= '0;
      gap           <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_idx_t'(cfg_index))
        REG_MODE:   mode          <= mode_t'(cfg_data[1:0]);
        REG_RED:    red_level     <= cfg_data[LEVEL_W-1:0];
        REG_GREEN:  green_level   <= cfg_data[LEVEL_W-1:0];
        REG_BLUE:   blue_level    <= cfg_data[LEVEL_W-1:0];
        REG_PERIOD: breath_period <= cfg_data[SPAN_W-1:0];
        REG_COUNT:  pulse_count   <= cfg_data[COUNT_W-1:0];
        REG_HALF:   pulse_half    <= cfg_data[SPAN_W-1:0];
        REG_GAP:    gap           <= cfg_data[SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_take  = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid || m_axis_tready;
  assign out_load = (state == ST_DONE) && out_free;

  // Fold the falling half of the breathing ramp back onto the rising one.
  assign t_mod  = div_rsp.remainder[SPAN_W-1:0];
  assign x_fold = (t_mod < (breath_period >> 1)) ? t_mod : (breath_period - t_mod);

  assign total      = TOTAL_W'(lit) + TOTAL_W'(gap);
  assign burst_over = elapsed > TIME_W'(total);
  assign in_gap     = elapsed > TIME_W'(lit);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_take) begin
          case (mode)
            MODE_BREATH: state_next = (breath_period == '0) ? ST_DONE : ST_BREATH_MOD;
            MODE_BLINK:  state_next = ST_BLINK_SPAN;
            default:     state_next = ST_DONE;
          endcase
        end
      end
      ST_BREATH_MOD:   if (div_rsp.done) state_next = ST_BREATH_SCALE;
      ST_BREATH_SCALE: state_next = ST_BREATH_DIV;
      ST_BREATH_DIV:   if (div_rsp.done) state_next = ST_DONE;
      ST_BLINK_SPAN:   state_next = ST_BLINK_TEST;
      ST_BLINK_TEST: begin
        if (burst_over || in_gap || (pulse_half == '0)) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_BLINK_DIV;
        end
      end
      ST_BLINK_DIV:    if (div_rsp.done) state_next = ST_DONE;
      ST_DONE:         if (out_free) state_next = ST_IDLE;
      default:         state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready    = (state == ST_IDLE);
    div_req.start    = 1'b0;
    div_req.dividend = s_axis_tdata;
    div_req.divisor  = {1'b0, breath_period};
    case (state)
      ST_IDLE: begin
        div_req.start = in_take && (mode == MODE_BREATH) && (breath_period != '0);
      end
      ST_BREATH_SCALE: begin
        div_req.start    = 1'b1;
        div_req.dividend = TIME_W'(prod);
      end
      ST_BLINK_TEST: begin
        div_req.start    = !(burst_over || in_gap || (pulse_half == '0));
        div_req.dividend = elapsed;
        div_req.divisor  = {pulse_half, 1'b0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      burst_start <= '0;
      bright      <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            case (mode)
              MODE_OFF:    bright <= '0;
              MODE_ON:     bright <= FULL_LEVEL;
              MODE_BREATH: if (breath_period == '0) bright <= '0;
              default: ;
            endcase
          end
        end
        ST_BREATH_DIV: begin
          if (div_rsp.done) begin
            bright <= (div_rsp.quotient > TIME_W'(FULL_LEVEL)) ?
                      FULL_LEVEL : div_rsp.quotient[LEVEL_W-1:0];
          end
        end
        ST_BLINK_TEST: begin
          if (burst_over) begin
            burst_start <= now_r;
          end else if (in_gap || (pulse_half == '0)) begin
            bright <= '0;
          end
        end
        ST_BLINK_DIV: begin
          if (div_rsp.done) begin
            bright <= (div_rsp.remainder > {1'b0, pulse_half}) ? FULL_LEVEL : '0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      now_r <= s_axis_tdata;
    end
    if ((state == ST_BREATH_MOD) && div_rsp.done) begin
      // x * 510 as a shift and subtract
      prod <= (PROD_W'(x_fold) << 9) - (PROD_W'(x_fold) << 1);
    end
    if (state == ST_BLINK_SPAN) begin
      lit     <= {(LIT_W-1)'(pulse_count) * (LIT_W-1)'(pulse_half), 1'b0};
      elapsed <= now_r - burst_start;
    end
    if (out_load) begin
      red_duty   <= DUTY_W'(red_level) * DUTY_W'(bright);
      green_duty <= DUTY_W'(green_level) * DUTY_W'(bright);
      blue_duty  <= DUTY_W'(blue_level) * DUTY_W'(bright);
      bright_out <= bright;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {bright_out, blue_duty, green_duty, red_duty};

  a_div_done_expected: assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == ST_BREATH_MOD || state == ST_BREATH_DIV ||
                      state == ST_BLINK_DIV))
    else $error("divider finished outside a waiting state");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> (div_req.divisor != '0))
    else $error("divider started with a zero divisor");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> ($past(state) == ST_DONE))
    else $error("result raised without finishing an item");

endmodule

FILE: tb/sv/tb_rgb_led_pattern_generator.sv
module tb_rgb_led_pattern_generator;
  import rlpg_pkg::*;

  localparam int CLK_PERIOD      = 12;
  localparam int RESET_CYCLES    = 8;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int RANDOM_ITEMS    = 750;
  localparam int STEADY_FROM     = 680;
  localparam int SETTLE_CYCLES   = 100;
  localparam int MAX_CYCLES      = 800000;

  // Same layout as m_axis_tdata, lowest field last.
  typedef struct packed {
    logic [LEVEL_W-1:0] brightness;
    logic [DUTY_W-1:0]  blue_duty;
    logic [DUTY_W-1:0]  green_duty;
    logic [DUTY_W-1:0]  red_duty;
  } duty_item_t;

  class duty_scoreboard;
    localparam int REPORT_LIMIT = 10;

    mode_t              mode;
    logic [LEVEL_W-1:0] red_level;
    logic [LEVEL_W-1:0] green_level;
    logic [LEVEL_W-1:0] blue_level;
    logic [SPAN_W-1:0]  period;
    logic [COUNT_W-1:0] count;
    logic [SPAN_W-1:0]  half;
    logic [SPAN_W-1:0]  gap;
    logic [TIME_W-1:0]  burst_start;
    logic [LEVEL_W-1:0] level;
    duty_item_t         expected_duties[$];
    int                 mismatches;

    function new();
      mode        = MODE_OFF;
      red_level   = '0;
      green_level = '0;
      blue_level  = '0;
      period      = '0;
      count       = '0;
      half        = '0;
      gap         = '0;
      burst_start = '0;
      level       = '0;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_MODE:   mode = mode_t'(data[1:0]);
        REG_RED:    red_level = data[LEVEL_W-1:0];
        REG_GREEN:  green_level = data[LEVEL_W-1:0];
        REG_BLUE:   blue_level = data[LEVEL_W-1:0];
        REG_PERIOD: period = data;
        REG_COUNT:  count = data[COUNT_W-1:0];
        REG_HALF:   half = data;
        REG_GAP:    gap = data;
        default: ;
      endcase
    endfunction

    // Triangular ramp over one period; the falling half saturates for odd periods.
    function logic [LEVEL_W-1:0] breath_level(logic [TIME_W-1:0] now);
      longint unsigned p;
      longint unsigned t;
      longint unsigned v;
      p = 64'(period);
      if (p == 0) return '0;
      t = now % p;
      if (t < p / 2) v = (t * 510) / p;
      else v = ((p - t) * 510) / p;
      if (v > 255) v = 255;
      return v[LEVEL_W-1:0];
    endfunction

    // A restart of the burst leaves the brightness as it was.
    function void blink_update(logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] lit_span;
      logic [TIME_W-1:0] total;
      logic [TIME_W-1:0] elapsed;
      logic [TIME_W-1:0] pulse_span;
      lit_span   = 32'd2 * count * half;
      total      = lit_span + gap;
      elapsed    = now - burst_start;
      pulse_span = 32'd2 * half;
      if (elapsed > total) burst_start = now;
      else if (elapsed > lit_span) level = '0;
      else if (half == '0) level = '0;
      else if ((elapsed % pulse_span) > half) level = FULL_LEVEL;
      else level = '0;
    endfunction

    function void note_input(logic [TIME_W-1:0] now);
      duty_item_t predicted;
      case (mode)
        MODE_OFF:    level = '0;
        MODE_ON:     level = FULL_LEVEL;
        MODE_BREATH: level = breath_level(now);
        default:     blink_update(now);
      endcase
      predicted.brightness = level;
      predicted.red_duty   = DUTY_W'(red_level) * DUTY_W'(level);
      predicted.green_duty = DUTY_W'(green_level) * DUTY_W'(level);
      predicted.blue_duty  = DUTY_W'(blue_level) * DUTY_W'(level);
      expected_duties.push_back(predicted);
    endfunction

    function void check_result(duty_item_t got);
      duty_item_t want;
      if (expected_duties.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result with nothing expected: red=%0d green=%0d blue=%0d bright=%0d",
                   $time, got.red_duty, got.green_duty, got.blue_duty, got.brightness);
        return;
      end
      want = expected_duties.pop_front();
      if (got.red_duty !== want.red_duty || got.green_duty !== want.green_duty ||
          got.blue_duty !== want.blue_duty || got.brightness !== want.brightness) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $write("%0t: expected red=%0d green=%0d blue=%0d bright=%0d, ",
                 $time, want.red_duty, want.green_duty, want.blue_duty, want.brightness);
          $display("got red=%0d green=%0d blue=%0d bright=%0d",
                   got.red_duty, got.green_duty, got.blue_duty, got.brightness);
        end
      end
    endfunction

    function int pending();
      return expected_duties.size();
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  bit             steady_run = 1'b0;
  bit             hold_off_req = 1'b0;
  duty_scoreboard duties;

  rgb_led_pattern_generator dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * MAX_CYCLES);
    $display("Simulation FAILED");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) duties.write_reg(cfg_index, cfg_data);
      if (s_axis_tvalid && s_axis_tready) duties.note_input(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) duties.check_result(m_axis_tdata);
    end
  end

  // The receiver stalls in short bursts, and once in a while for a long stretch
  // so that the output register fills and the input side backs up.
  initial begin : receiver
    int span;
    wait (rst == 1'b0);
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else if (!steady_run && $urandom_range(0, 99) < 8) begin
        span = $urandom_range(1, 10);
        m_axis_tready <= 1'b0;
        repeat (span) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_item(input logic [TIME_W-1:0] now);
    s_axis_tdata  <= now;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    if (!steady_run && $urandom_range(0, 99) < 25) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
  endtask

  // Every item gives a result, so an empty queue means the block is idle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (duties.pending() != 0);
  endtask

  initial begin : stimulus
    reg_idx_t           color_regs[3];
    mode_t              mode_pick;
    logic [LEVEL_W-1:0] lvl;
    logic [SPAN_W-1:0]  span;
    logic [TIME_W-1:0]  now;
    int                 sent;
    int                 phase;
    int                 n;
    int                 stride;
    bit                 noisy;

    color_regs = '{REG_RED, REG_GREEN, REG_BLUE};
    duties = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Off after reset, then steady on with full, zero and half colour levels.
    send_item(32'h0000_0000);
    send_item(32'hFFFF_FFFF);
    drain();
    set_reg(REG_RED, 16'd255);
    set_reg(REG_GREEN, 16'd0);
    set_reg(REG_BLUE, 16'd128);
    set_reg(REG_MODE, {14'd0, MODE_ON});
    send_item(32'h5555_5555);
    send_item(32'hAAAA_AAAA);
    drain();

    // Breathing, selected with junk in the upper data bits; zero period first.
    set_reg(REG_MODE, {14'h3FFF, MODE_BREATH});
    set_reg(8'd8, 16'h0007);
    set_reg(8'd255, 16'hFFFF);
    send_item(32'd1234);
    drain();
    set_reg(REG_PERIOD, 16'd1);
    send_item(32'd7);
    drain();
    // An odd period makes the midpoint of the falling half saturate.
    set_reg(REG_PERIOD, 16'd5);
    send_item(32'd2);
    send_item(32'd1);
    send_item(32'd4);
    send_item(32'd3);
    drain();
    set_reg(REG_PERIOD, 16'hFFFF);
    send_item(32'hFFFF_FFFF);
    send_item(32'd32767);
    send_item(32'd32766);
    drain();

    // Blinking: two pulses of three ms halves and a four ms gap.
    set_reg(REG_COUNT, 16'd2);
    set_reg(REG_HALF, 16'd3);
    set_reg(REG_GAP, 16'd4);
    set_reg(REG_MODE, {14'd0, MODE_BLINK});
    send_item(32'd5);
    send_item(32'd6);
    send_item(32'd13);
    send_item(32'd11);
    send_item(32'd40);
    send_item(32'd44);
    drain();
    // A zero pulse length keeps the LED dark.
    set_reg(REG_COUNT, 16'hFFFF);
    set_reg(REG_HALF, 16'd0);
    send_item(32'd44);
    send_item(32'd46);
    drain();
    // Longest burst, with the elapsed time wrapping through zero.
    set_reg(REG_HALF, 16'hFFFF);
    set_reg(REG_GAP, 16'hFFFF);
    send_item(32'hFFFF_FFF0);
    send_item(32'h0000_0010);
    send_item(32'h0001_0000);

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      drain();
      if (sent >= STEADY_FROM) steady_run = 1'b1;

      case ($urandom_range(0, 9))
        0:       mode_pick = MODE_OFF;
        1:       mode_pick = MODE_ON;
        2, 3, 4: mode_pick = MODE_BREATH;
        default: mode_pick = MODE_BLINK;
      endcase
      if ($urandom_range(0, 3) == 0) set_reg(REG_MODE, {14'($urandom), mode_pick});
      else set_reg(REG_MODE, {14'd0, mode_pick});

      foreach (color_regs[c]) begin
        if ($urandom_range(0, 9) < 7) begin
          if ($urandom_range(0, 3) == 0) lvl = $urandom_range(0, 1) ? 8'd255 : 8'd0;
          else lvl = 8'($urandom);
          if ($urandom_range(0, 3) == 0) set_reg(color_regs[c], {8'($urandom), lvl});
          else set_reg(color_regs[c], {8'd0, lvl});
        end
      end

      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 5))
          0:       span = 16'd0;
          1:       span = 16'($urandom_range(1, 3));
          2, 3:    span = 16'($urandom_range(4, 300));
          4:       span = 16'($urandom);
          default: span = 16'hFFFF;
        endcase
        set_reg(REG_PERIOD, span);
      end
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 5))
          0:       lvl = 8'd0;
          1:       lvl = 8'd255;
          default: lvl = 8'($urandom_range(1, 8));
        endcase
        if ($urandom_range(0, 3) == 0) set_reg(REG_COUNT, {8'($urandom), lvl});
        else set_reg(REG_COUNT, {8'd0, lvl});
      end
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 7))
          0:       span = 16'd0;
          1:       span = 16'hFFFF;
          default: span = 16'($urandom_range(1, 25));
        endcase
        set_reg(REG_HALF, span);
      end
      if ($urandom_range(0, 9) < 7) begin
        case ($urandom_range(0, 5))
          0:       span = 16'd0;
          1:       span = 16'hFFFF;
          default: span = 16'($urandom_range(0, 60));
        endcase
        set_reg(REG_GAP, span);
      end
      if ($urandom_range(0, 9) == 0) set_reg(8'($urandom_range(8, 255)), 16'($urandom));

      // Mostly rising timestamps, as a real millisecond tick gives them.
      case ($urandom_range(0, 3))
        0:       stride = 3;
        1:       stride = 25;
        2:       stride = 600;
        default: stride = 20000;
      endcase
      if ($urandom_range(0, 4) == 0) now = 32'hFFFF_FFFF - 32'($urandom_range(0, 400));
      else now = $urandom;
      noisy = ($urandom_range(0, 6) == 0);
      n = $urandom_range(10, 40);
      if (phase == 3 || phase == 14) hold_off_req = 1'b1;
      for (int k = 0; k < n; k++) begin
        send_item(now);
        if (noisy) now = $urandom;
        else now = now + 32'($urandom_range(1, stride));
      end
      sent += n;
      phase++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (duties.mismatches == 0 && duties.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
